/* rtl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_MAX_PATTERN_BYTES = 32;
  localparam int DEFAULT_ADDRESS_BITS      = 48;

  // Pattern storage: four 64-bit words of eight bytes each.
  localparam int PATTERN_WORDS        = 4;
  localparam int PATTERN_WORD_BITS    = 64;
  localparam int PATTERN_BYTES_STORED = PATTERN_WORDS * 8;
  localparam int PATTERN_INDEX_BITS   = $clog2(PATTERN_BYTES_STORED);
  localparam int PATTERN_LENGTH_BITS  = 6;

  // A pattern byte of this value matches any data byte.
  localparam logic [7:0] WILDCARD = 8'h00;

  // Configuration port.
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIND_ALL       = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_COUNT     = 3'd6;

  // Match counter.
  localparam int               COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 16'hFFFF;

  // Reset values of the registers that are not all zero.
  localparam logic [PATTERN_LENGTH_BITS-1:0] PATTERN_LENGTH_RESET = 6'd1;
  localparam logic [COUNT_BITS-1:0]          STOP_COUNT_RESET     = 16'd1;

  // Depth of the event queue and the result queue.
  localparam int QUEUE_DEPTH = 2;

  // Per-byte event handed from the front end to the match controller.
  typedef struct packed {
    logic hit;
    logic region_first;
    logic scan_begin;
  } evt_flags_t;

  // Mode settings used by the match controller.
  typedef struct packed {
    logic                  find_all;
    logic [COUNT_BITS-1:0] stop_count;
  } back_cfg_t;

endpackage

/* rtl/wildcard_byte_pattern_scanner.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams memory bytes through a window and reports wildcard pattern matches.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                         | transfer when
//   ---------+-----------------------------------------------+----------------
//   input    | in_data_byte, in_byte_address, in_region_first, in_scan_begin
//            |                                               | in_push & !in_full
//   result   | out_match_address, out_match_number           | out_pop & !out_empty
//   config   | cfg_index, cfg_data                           | cfg_wr_en
//
// One byte is accepted every cycle while in_full is low. The front end
// shifts it into the window and compares all slots in parallel in the accept
// cycle; the match controller handles one event per cycle while the result
// queue has room, and each result is registered in the result queue first.
// Synchronous reset restores the register defaults and empties both queues.
// A stalled result side fills the result queue, then the event queue, and
// only then raises in_full.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::DEFAULT_MAX_PATTERN_BYTES,
  parameter int ADDRESS_BITS      = wbps_pkg::DEFAULT_ADDRESS_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [7:0]                          in_data_byte,
  input  logic [ADDRESS_BITS-1:0]             in_byte_address,
  input  logic                                in_region_first,
  input  logic                                in_scan_begin,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [ADDRESS_BITS-1:0]             out_match_address,
  output logic [wbps_pkg::COUNT_BITS-1:0]     out_match_number,
  input  logic                                cfg_wr_en,
  input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int FLAG_W = $bits(wbps_pkg::evt_flags_t);
  localparam int EVT_W  = FLAG_W + ADDRESS_BITS;
  localparam int RES_W  = ADDRESS_BITS + wbps_pkg::COUNT_BITS;

  wbps_pkg::back_cfg_t             back_cfg;
  logic [MAX_PATTERN_BYTES*8-1:0]  aligned_pattern;
  logic [FILL_W-1:0]               used_len;
  logic [FILL_W-1:0]               len_m1;
  logic                            in_accept;
  wbps_pkg::evt_flags_t            front_flags;
  logic [ADDRESS_BITS-1:0]         front_address;
  logic [EVT_W-1:0]                evt_dout;
  logic                            evt_empty;
  logic                            evt_take;
  wbps_pkg::evt_flags_t            back_flags;
  logic [ADDRESS_BITS-1:0]         back_address;
  logic                            res_full;
  logic                            res_push;
  logic [ADDRESS_BITS-1:0]         res_address;
  logic [wbps_pkg::COUNT_BITS-1:0] res_number;
  logic [RES_W-1:0]                res_dout;

  assign in_accept = in_push && !in_full;

  // Configuration registers.
  wbps_cfg #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .FILL_W            (FILL_W)
  ) u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .back_cfg        (back_cfg),
    .aligned_pattern (aligned_pattern),
    .used_len        (used_len),
    .len_m1          (len_m1)
  );

  // Front end: window and compare.
  wbps_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .ADDRESS_BITS      (ADDRESS_BITS),
    .FILL_W            (FILL_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .data_byte       (in_data_byte),
    .byte_address    (in_byte_address),
    .region_first    (in_region_first),
    .scan_begin      (in_scan_begin),
    .aligned_pattern (aligned_pattern),
    .used_len        (used_len),
    .len_m1          (len_m1),
    .evt_flags       (front_flags),
    .evt_address     (front_address)
  );

  // Event queue between front end and match controller.
  wbps_fifo #(
    .WIDTH (EVT_W),
    .DEPTH (wbps_pkg::QUEUE_DEPTH)
  ) u_evt_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .din   ({front_flags, front_address}),
    .full  (in_full),
    .pop   (evt_take),
    .dout  (evt_dout),
    .empty (evt_empty)
  );

  assign back_flags   = wbps_pkg::evt_flags_t'(evt_dout[EVT_W-1 -: FLAG_W]);
  assign back_address = evt_dout[ADDRESS_BITS-1:0];

  // Match controller.
  wbps_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .back_cfg    (back_cfg),
    .evt_valid   (!evt_empty),
    .evt_flags   (back_flags),
    .evt_address (back_address),
    .res_full    (res_full),
    .evt_take    (evt_take),
    .res_push    (res_push),
    .res_address (res_address),
    .res_number  (res_number)
  );

  // Result queue toward the output.
  wbps_fifo #(
    .WIDTH (RES_W),
    .DEPTH (wbps_pkg::QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   ({res_address, res_number}),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_match_address = res_dout[RES_W-1 -: ADDRESS_BITS];
  assign out_match_number  = res_dout[wbps_pkg::COUNT_BITS-1:0];

endmodule

/* rtl/wbps_fifo.sv */
// ----------------------------------------------------------------------------
// wbps_fifo
// Small register-based FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module wbps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wbps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Pointer and occupancy updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* rtl/wbps_cfg.sv */
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration registers and the pattern aligned to the byte window.
// ----------------------------------------------------------------------------
module wbps_cfg #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::DEFAULT_MAX_PATTERN_BYTES,
  parameter int FILL_W            = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output wbps_pkg::back_cfg_t                    back_cfg,
  output logic [MAX_PATTERN_BYTES*8-1:0]         aligned_pattern,
  output logic [FILL_W-1:0]                      used_len,
  output logic [FILL_W-1:0]                      len_m1
);

  localparam int MAXB   = MAX_PATTERN_BYTES;
  localparam int STORED = wbps_pkg::PATTERN_BYTES_STORED;
  localparam int WORD_W = wbps_pkg::PATTERN_WORD_BITS;
  localparam int LEN_W  = wbps_pkg::PATTERN_LENGTH_BITS;

  logic [WORD_W-1:0]              pat_r   [wbps_pkg::PATTERN_WORDS];
  logic [WORD_W-1:0]              pat_nxt [wbps_pkg::PATTERN_WORDS];
  logic [LEN_W-1:0]               len_r, len_nxt;
  logic                           fa_r, fa_nxt;
  logic [wbps_pkg::COUNT_BITS-1:0] sc_r, sc_nxt;
  logic [MAXB*8-1:0]              ali_r, ali_nxt;
  logic [FILL_W-1:0]              used_r, used_nxt;
  logic [STORED*8-1:0]            pat_flat_nxt;

  // Register writes.
  always_comb begin
    pat_nxt = pat_r;
    len_nxt = len_r;
    fa_nxt  = fa_r;
    sc_nxt  = sc_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        wbps_pkg::REG_PATTERN_WORD_0: pat_nxt[0] = cfg_data;
        wbps_pkg::REG_PATTERN_WORD_1: pat_nxt[1] = cfg_data;
        wbps_pkg::REG_PATTERN_WORD_2: pat_nxt[2] = cfg_data;
        wbps_pkg::REG_PATTERN_WORD_3: pat_nxt[3] = cfg_data;
        wbps_pkg::REG_PATTERN_LENGTH: len_nxt = cfg_data[LEN_W-1:0];
        wbps_pkg::REG_FIND_ALL:       fa_nxt  = cfg_data[0];
        wbps_pkg::REG_STOP_COUNT:     sc_nxt  = cfg_data[wbps_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: zero acts as one, anything too long as the window size.
  always_comb begin
    if (len_nxt == '0) begin
      used_nxt = FILL_W'(1);
    end else if (int'(len_nxt) > MAXB) begin
      used_nxt = FILL_W'(MAXB);
    end else begin
      used_nxt = FILL_W'(len_nxt);
    end
  end

  // Align the pattern so that window slot i (newest first) faces pattern
  // byte used-1-i. Slots beyond the length, and bytes without a register,
  // become wildcards. This is computed from the next register values so the
  // aligned copy is ready in the same cycle as the registers themselves.
  always_comb begin
    int               k;
    logic [wbps_pkg::PATTERN_INDEX_BITS-1:0] kk;
    for (int w = 0; w < wbps_pkg::PATTERN_WORDS; w++) begin
      pat_flat_nxt[w*WORD_W +: WORD_W] = pat_nxt[w];
    end
    for (int i = 0; i < MAXB; i++) begin
      ali_nxt[i*8 +: 8] = wbps_pkg::WILDCARD;
      k  = int'(used_nxt) - 1 - i;
      kk = k[wbps_pkg::PATTERN_INDEX_BITS-1:0];
      if (k >= 0 && k < STORED) begin
        ali_nxt[i*8 +: 8] = pat_flat_nxt[kk*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < wbps_pkg::PATTERN_WORDS; w++) begin
        pat_r[w] <= '0;
      end
      len_r  <= wbps_pkg::PATTERN_LENGTH_RESET;
      fa_r   <= 1'b0;
      sc_r   <= wbps_pkg::STOP_COUNT_RESET;
      ali_r  <= '0;
      used_r <= FILL_W'(1);
    end else begin
      pat_r  <= pat_nxt;
      len_r  <= len_nxt;
      fa_r   <= fa_nxt;
      sc_r   <= sc_nxt;
      ali_r  <= ali_nxt;
      used_r <= used_nxt;
    end
  end

  assign back_cfg.find_all   = fa_r;
  assign back_cfg.stop_count = sc_r;
  assign aligned_pattern     = ali_r;
  assign used_len            = used_r;
  assign len_m1              = used_r - 1'b1;

endmodule

/* rtl/wbps_front.sv */
// ----------------------------------------------------------------------------
// wbps_front
// Byte window, fill tracking and parallel wildcard compare for each byte.
// ----------------------------------------------------------------------------
module wbps_front #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::DEFAULT_MAX_PATTERN_BYTES,
  parameter int ADDRESS_BITS      = wbps_pkg::DEFAULT_ADDRESS_BITS,
  parameter int FILL_W            = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [7:0]                     data_byte,
  input  logic [ADDRESS_BITS-1:0]        byte_address,
  input  logic                           region_first,
  input  logic                           scan_begin,
  input  logic [MAX_PATTERN_BYTES*8-1:0] aligned_pattern,
  input  logic [FILL_W-1:0]              used_len,
  input  logic [FILL_W-1:0]              len_m1,
  output wbps_pkg::evt_flags_t           evt_flags,
  output logic [ADDRESS_BITS-1:0]        evt_address
);

  localparam int MAXB = MAX_PATTERN_BYTES;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAXB);

  logic [7:0]        win_r   [MAXB];
  logic [7:0]        win_nxt [MAXB];
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_base;
  logic [MAXB-1:0]   slot_ok;

  // The window restarts at every region start; it saturates when full.
  assign fill_base = (scan_begin || region_first) ? '0 : fill_r;
  assign fill_nxt  = (fill_base == FILL_FULL) ? FILL_FULL : fill_base + 1'b1;

  // Shift the new byte in at slot zero.
  always_comb begin
    win_nxt[0] = data_byte;
    for (int i = 1; i < MAXB; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  // Each slot compares against its aligned pattern byte.
  always_comb begin
    for (int i = 0; i < MAXB; i++) begin
      slot_ok[i] = (aligned_pattern[i*8 +: 8] == wbps_pkg::WILDCARD) ||
                   (aligned_pattern[i*8 +: 8] == win_nxt[i]);
    end
  end

  assign evt_flags.hit          = (&slot_ok) && (fill_nxt >= used_len);
  assign evt_flags.region_first = region_first;
  assign evt_flags.scan_begin   = scan_begin;
  assign evt_address            = byte_address - ADDRESS_BITS'(len_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // Window bytes are only looked at below the fill level.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

/* rtl/wbps_back.sv */
// ----------------------------------------------------------------------------
// wbps_back
// Match controller: region and scan bookkeeping, stop test and counting.
// ----------------------------------------------------------------------------
module wbps_back #(
  parameter int ADDRESS_BITS = wbps_pkg::DEFAULT_ADDRESS_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wbps_pkg::back_cfg_t             back_cfg,
  input  logic                            evt_valid,
  input  wbps_pkg::evt_flags_t            evt_flags,
  input  logic [ADDRESS_BITS-1:0]         evt_address,
  input  logic                            res_full,
  output logic                            evt_take,
  output logic                            res_push,
  output logic [ADDRESS_BITS-1:0]         res_address,
  output logic [wbps_pkg::COUNT_BITS-1:0] res_number
);

  logic [wbps_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                            matched_r, matched_nxt;
  logic                            stopped_r, stopped_nxt;
  logic                            report;

  // One event is taken per cycle while the result queue has room.
  assign evt_take = evt_valid && !res_full;

  always_comb begin
    count_nxt   = count_r;
    matched_nxt = matched_r;
    stopped_nxt = stopped_r;
    report      = 1'b0;
    // Scan start clears everything; a plain region start runs the stop test.
    if (evt_flags.scan_begin) begin
      count_nxt   = '0;
      matched_nxt = 1'b0;
      stopped_nxt = 1'b0;
    end else if (evt_flags.region_first) begin
      if ((!back_cfg.find_all && matched_r) ||
          (back_cfg.find_all && (back_cfg.stop_count != '0) &&
           (count_r >= back_cfg.stop_count))) begin
        stopped_nxt = 1'b1;
      end
      matched_nxt = 1'b0;
    end
    // Report the hit unless stopped or a repeat in first-only mode.
    if (evt_flags.hit && !stopped_nxt && (back_cfg.find_all || !matched_nxt)) begin
      report      = 1'b1;
      matched_nxt = 1'b1;
      if (count_nxt != wbps_pkg::COUNT_MAX) begin
        count_nxt = count_nxt + 1'b1;
      end
    end
  end

  assign res_push    = evt_take && report;
  assign res_address = evt_address;
  assign res_number  = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      matched_r <= 1'b0;
      stopped_r <= 1'b0;
    end else if (evt_take) begin
      count_r   <= count_nxt;
      matched_r <= matched_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule
